// ===== src/heard_station_table_with_aging_macros.svh =====
// Assertion macros for the heard station table.
`ifndef HEARD_STATION_TABLE_WITH_AGING_MACROS_SVH
`define HEARD_STATION_TABLE_WITH_AGING_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is low.
`define HSTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define HSTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hsta_pkg.sv =====
package hsta_pkg;

  // Item classes, coded as the mode field
  typedef enum logic [1:0] {
    OP_HEARD   = 2'd0,
    OP_SERVER  = 2'd1,
    OP_TICK    = 2'd2,
    OP_FORWARD = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] REG_STATION_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_BEACON_INTERVAL = 2'd1;
  localparam logic [1:0] REG_LINK_TIMEOUT    = 2'd2;

  // Reset values
  localparam logic [15:0] RESET_STATION_TIMEOUT = 16'd1800;
  localparam logic [15:0] RESET_BEACON_INTERVAL = 16'd1800;
  localparam logic [15:0] RESET_LINK_TIMEOUT    = 16'd45;
  localparam logic [31:0] RESET_NEXT_BEACON     = 32'(RESET_BEACON_INTERVAL / 2);

  // Last address byte is compared under this mask
  localparam logic [7:0] SSID_MASK = 8'h1E;

  // Depth of the request queue between front and back
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [15:0] station_timeout;
    logic [15:0] beacon_interval;
    logic [15:0] link_timeout;
  } cfg_regs_t;

  typedef struct packed {
    op_e         op;
    logic [55:0] addr;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  local_count;
    logic [31:0] message_count;
    logic        beacon_due;
    logic        link_timed_out;
    logic        inserted;
    logic        table_full;
  } res_t;

  // Station address compare: six bytes exact, last byte under SSID mask
  function automatic logic addr_match(logic [55:0] a, logic [55:0] b);
    logic hi_eq;
    logic lo_eq;
    hi_eq = (a[55:8] == b[55:8]);
    lo_eq = (((a[7:0] ^ b[7:0]) & SSID_MASK) == 8'h00);
    return hi_eq && lo_eq;
  endfunction

endpackage

// ===== src/hsta_front.sv =====
module hsta_front import hsta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [55:0] station_address_i,
  input  logic [31:0] now_seconds_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  localparam int unsigned PtrW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CMD_FIFO_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CMD_FIFO_DEPTH - 1);

  cmd_t            fifo_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;
  cmd_t            cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.op   = op_e'(mode_i);
    cmd_in.addr = (cmd_in.op == OP_HEARD) ? station_address_i : 56'd0;
    cmd_in.now  = now_seconds_i;
  end

  assign full        = (cnt_q == FullCnt);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/hsta_back.sv =====
module hsta_back import hsta_pkg::*; #(
  parameter int unsigned TableDepth = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output res_t      res_o,
  input  logic      res_ready_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]      state_q, state_d;
  cmd_t            cur_q;
  logic [CntW-1:0] rd_cnt_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [55:0]     addr_rd_q;
  logic [31:0]     time_rd_q;
  logic            free_vld_q;
  logic [IdxW-1:0] free_idx_q;
  logic [TableDepth-1:0] valid_q;
  logic [CntW-1:0] count_q;
  logic [31:0]     fwd_q;
  logic [31:0]     next_beacon_q;
  logic [31:0]     last_srv_q;
  logic            beacon_q, timeout_q, ins_q, full_q;

  logic [55:0]     addr_mem [TableDepth];
  logic [31:0]     time_mem [TableDepth];

  logic            in_scan, issue, cmp_bit, hit, expire, scan_end;
  logic            link_dead, beacon_hit, insert_ok;
  logic [IdxW-1:0] rd_idx, time_widx;
  logic            time_we, addr_we;
  logic [31:0]     age, link_age, beacon_delta;

  // Sweep control: one memory read issued per cycle, compared the next
  assign in_scan  = (state_q == ST_SCAN);
  assign rd_idx   = rd_cnt_q[IdxW-1:0];
  assign cmp_bit  = valid_q[cmp_idx_q];
  assign age      = cur_q.now - time_rd_q;
  assign hit      = in_scan && cmp_vld_q && (cur_q.op == OP_HEARD) && cmp_bit &&
                    addr_match(addr_rd_q, cur_q.addr);
  assign expire   = in_scan && cmp_vld_q && (cur_q.op == OP_TICK) && cmp_bit &&
                    (age > 32'(cfg_i.station_timeout));
  assign issue    = in_scan && (rd_cnt_q != DepthCnt) && !hit;
  assign scan_end = in_scan && (rd_cnt_q == DepthCnt) && !cmp_vld_q;

  // Link and beacon checks
  assign link_age     = cur_q.now - last_srv_q;
  assign link_dead    = link_age > 32'(cfg_i.link_timeout);
  assign beacon_delta = cur_q.now - next_beacon_q;
  assign beacon_hit   = (beacon_delta != 32'd0) && !beacon_delta[31];

  // Memory write ports
  assign insert_ok = scan_end && (cur_q.op == OP_HEARD) && free_vld_q;
  assign addr_we   = insert_ok;
  assign time_we   = hit || insert_ok;
  assign time_widx = hit ? cmp_idx_q : free_idx_q;

  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[free_idx_q] <= cur_q.addr;
    end
    if (time_we) begin
      time_mem[time_widx] <= cur_q.now;
    end
    addr_rd_q <= addr_mem[rd_idx];
    time_rd_q <= time_mem[rd_idx];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cur_q.op == OP_HEARD) begin
          state_d = ST_SCAN;
        end else if (cur_q.op == OP_TICK) begin
          state_d = link_dead ? ST_DONE : ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Request and compare-stage payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cur_q <= cmd_i;
    end
    cmp_idx_q <= rd_idx;
    if (in_scan && cmp_vld_q && !cmp_bit && !free_vld_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // Control state and table bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rd_cnt_q      <= '0;
      cmp_vld_q     <= 1'b0;
      free_vld_q    <= 1'b0;
      valid_q       <= '0;
      count_q       <= '0;
      fwd_q         <= '0;
      next_beacon_q <= RESET_NEXT_BEACON;
      last_srv_q    <= '0;
      beacon_q      <= 1'b0;
      timeout_q     <= 1'b0;
      ins_q         <= 1'b0;
      full_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          beacon_q  <= 1'b0;
          timeout_q <= 1'b0;
          ins_q     <= 1'b0;
          full_q    <= 1'b0;
        end
        ST_EXEC: begin
          rd_cnt_q   <= '0;
          free_vld_q <= 1'b0;
          unique case (cur_q.op)
            OP_SERVER:  last_srv_q <= cur_q.now;
            OP_FORWARD: if (fwd_q != '1) fwd_q <= fwd_q + 1'b1;
            OP_TICK:    timeout_q <= link_dead;
            OP_HEARD:   ;
            default:    ;
          endcase
        end
        ST_SCAN: begin
          if (cmp_vld_q && !cmp_bit) begin
            free_vld_q <= 1'b1;
          end
          if (expire) begin
            valid_q[cmp_idx_q] <= 1'b0;
            count_q            <= count_q - 1'b1;
          end
          if (scan_end) begin
            if (cur_q.op == OP_HEARD) begin
              if (free_vld_q) begin
                valid_q[free_idx_q] <= 1'b1;
                count_q             <= count_q + 1'b1;
                ins_q               <= 1'b1;
              end else begin
                full_q <= 1'b1;
              end
            end else if (beacon_hit) begin
              beacon_q      <= 1'b1;
              next_beacon_q <= cur_q.now + 32'(cfg_i.beacon_interval);
            end
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o.local_count    = 6'(count_q);
    res_o.message_count  = fwd_q;
    res_o.beacon_due     = beacon_q;
    res_o.link_timed_out = timeout_q;
    res_o.inserted       = ins_q;
    res_o.table_full     = full_q;
  end

endmodule

// ===== src/heard_station_table_with_aging.sv =====
// From the accepting edge, an item passes the request queue, the back end's idle and exec states,
// a sweep of all TABLE_DEPTH entries for a missed heard frame or a live-link tick (ending at entry k
// for a hit in entry k; one-entry-per-cycle sweep), the done state and then the result register.
// Server-data, forwarded-message and dead-link tick items skip the sweep. One item is worked at a time;
// a two-entry request queue and the result register let push and pop stall independently.
// Asynchronous active-low reset clears all entries and counters and loads register defaults.
`include "heard_station_table_with_aging_macros.svh"

module heard_station_table_with_aging import hsta_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [55:0] station_address_i,
  input  logic [31:0] now_seconds_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  local_count_o,
  output logic [31:0] message_count_o,
  output logic        beacon_due_o,
  output logic        link_timed_out_o,
  output logic        inserted_o,
  output logic        table_full_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_regs_t cfg_q;
  logic      cmd_valid, cmd_pop;
  cmd_t      cmd;
  logic      res_valid, res_ready;
  res_t      res, out_q;
  logic      out_vld_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_timeout <= RESET_STATION_TIMEOUT;
      cfg_q.beacon_interval <= RESET_BEACON_INTERVAL;
      cfg_q.link_timeout    <= RESET_LINK_TIMEOUT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_STATION_TIMEOUT: cfg_q.station_timeout <= cfg_data_i;
        REG_BEACON_INTERVAL: cfg_q.beacon_interval <= cfg_data_i;
        REG_LINK_TIMEOUT:    cfg_q.link_timeout    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: classify and queue requests
  hsta_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .mode_i            (mode_i),
    .station_address_i (station_address_i),
    .now_seconds_i     (now_seconds_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  // Back: table sweeps and counters
  hsta_back #(
    .TableDepth (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Result register
  assign res_ready = !out_vld_q || pop;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  assign empty            = !out_vld_q;
  assign local_count_o    = out_q.local_count;
  assign message_count_o  = out_q.message_count;
  assign beacon_due_o     = out_q.beacon_due;
  assign link_timed_out_o = out_q.link_timed_out;
  assign inserted_o       = out_q.inserted;
  assign table_full_o     = out_q.table_full;

  // Checks
  `HSTA_ASSERT_IMP(a_ins_excl_full, clk_i, rst_ni, !empty && inserted_o, !table_full_o)
  `HSTA_ASSERT_IMP(a_full_count, clk_i, rst_ni, !empty && table_full_o, local_count_o == 6'(TABLE_DEPTH))
  `HSTA_ASSERT_IMP(a_dead_link_quiet, clk_i, rst_ni, !empty && link_timed_out_o, !beacon_due_o && !inserted_o)
  `HSTA_ASSERT_NEXT(a_res_loaded, clk_i, rst_ni, res_valid && res_ready, !empty)

endmodule
